/* sv/assert_macros.svh */
// Assertion macros used by wpce_checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define WPCE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WPCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/wpce_pkg.sv */
// Package for the waypoint path cost estimator: field widths, register
// indexes, constants and the status struct of the serial units. No dependencies.
`default_nettype none
package wpce_pkg;
    localparam int COORD_BITS_DEF = 24;
    localparam int DIST_BITS_DEF  = 40;
    localparam int REG_W   = 16;
    localparam int IDX_W   = 8;
    localparam int OVR_W   = 41;
    localparam int CNT_W   = 16;
    localparam int ETA_W   = 47;
    localparam int DROP_W  = 26;
    localparam int PROJ_W  = 27;
    localparam int DIVR_W  = 20;
    localparam logic [IDX_W-1:0] REG_SPEED   = 8'd0;
    localparam logic [IDX_W-1:0] REG_BATTERY = 8'd1;
    localparam logic [IDX_W-1:0] REG_DROP    = 8'd2;
    localparam logic [IDX_W-1:0] REG_MIN_BAT = 8'd3;
    localparam logic [REG_W-1:0] SPEED_RESET = 16'd1000;
    localparam logic [REG_W-1:0] SPEED_FLOOR = 16'd10;
    localparam logic [DIVR_W-1:0] DROP_DIVISOR = 20'd1000000;
    localparam logic CMD_WAYPOINT = 1'b0;
    localparam logic CMD_OVERRIDE = 1'b1;
    localparam logic SRC_PATH     = 1'b0;
    localparam logic SRC_OVERRIDE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } su_stat_t;
endpackage
`default_nettype wire

/* sv/wpce_smul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on wpce_pkg for the unit status struct.
`default_nettype none
module wpce_smul
    import wpce_pkg::*;
#(
    parameter int AW = 40,
    parameter int BW = 25
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [AW-1:0]   a,
    input  wire logic [BW-1:0]   b,
    output logic [AW+BW-1:0]     prod,
    output su_stat_t             stat
);
    localparam int CW = $clog2(BW + 1);

    logic            busy_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [AW-1:0]   a_reg;
    logic [BW-1:0]   b_reg;
    logic [AW+BW-1:0] acc_reg, acc_next;

    assign acc_next = {acc_reg[AW+BW-2:0], 1'b0}
                      + (b_reg[BW-1] ? (AW+BW)'(a_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[BW-2:0], 1'b0};
        end
    end

    assign prod = acc_reg;
    assign stat = '{busy: busy_reg, done: done_reg};
endmodule
`default_nettype wire

/* sv/wpce_ssqrt.sv */
// Digit-serial integer square root, two radicand bits and one root bit per cycle.
// Depends on wpce_pkg for the unit status struct.
`default_nettype none
module wpce_ssqrt
    import wpce_pkg::*;
#(
    parameter int RW = 26
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] rad,
    output logic [RW-1:0]        root,
    output su_stat_t             stat
);
    localparam int CW = $clog2(RW + 1);

    logic              busy_reg, done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [2*RW-1:0]   rad_reg;
    logic [RW+1:0]     rem_reg;
    logic [RW-1:0]     root_reg;
    logic [RW+3:0]     rem_sh, trial;
    logic              ge;

    assign rem_sh = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
    assign trial  = (RW+4)'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= (RW+2)'(ge ? rem_sh - trial : rem_sh);
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};
endmodule
`default_nettype wire

/* sv/wpce_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wpce_pkg for the unit status struct.
`default_nettype none
module wpce_sdiv
    import wpce_pkg::*;
#(
    parameter int NW = 56,
    parameter int DW = 20
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic [NW-1:0]      quo,
    output su_stat_t           stat
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] nq_reg;
    logic [DW-1:0] den_reg, rem_reg;
    logic [DW:0]   sh;
    logic          ge;

    assign sh = {rem_reg, nq_reg[NW-1]};
    assign ge = sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= DW'(ge ? sh - {1'b0, den_reg} : sh);
            nq_reg  <= {nq_reg[NW-2:0], ge};
        end
    end

    assign quo  = nq_reg;
    assign stat = '{busy: busy_reg, done: done_reg};
endmodule
`default_nettype wire

/* sv/waypoint_path_cost_estimator.sv */
// Top level of the waypoint path cost estimator: path state, sequencer, output register.
// Depends on wpce_pkg, wpce_smul, wpce_ssqrt and wpce_sdiv.
//
//   channel   dir  handshake            payload
//   s_axis    in   s_tvalid/s_tready    s_tdata, s_tuser=command, s_tlast=last_point
//   m_axis    out  m_tvalid/m_tready    m_tdata, m_tuser=source
//   cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A waypoint with a predecessor takes a dispatch state, two serial squares, a square
// root and an accumulate state; without a predecessor it takes dispatch and accumulate
// only. An emitted result adds two divides (ETA, drop), one multiply and one output load.
// One request at a time; s_tready is high only while idle. A result waiting on
// m_tready holds the sequencer. Reset is asynchronous, active low; no clearing pass.
// cfg_ready is always high.
`default_nettype none
module waypoint_path_cost_estimator
    import wpce_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF,
    localparam int IN_W   = 2*COORD_BITS + OVR_W + CNT_W,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = DIST_BITS + ETA_W + DROP_W + PROJ_W + 1 + CNT_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, override_distance, override_count
    input  wire logic [IN_TW-1:0]  s_tdata,
    // command
    input  wire logic              s_tuser,
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // distance_mm, eta_ms, drop_mv, projected_mv, sufficient, point_count
    output logic [OUT_TW-1:0]      m_tdata,
    // source
    output logic                   m_tuser,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [REG_W-1:0]  cfg_data
);
    localparam int DXW  = COORD_BITS + 1;
    localparam int RW   = DXW + 1;
    localparam int MA   = (DIST_BITS > DXW) ? DIST_BITS : DXW;
    localparam int MB   = (DXW > REG_W) ? DXW : REG_W;
    localparam int NW   = DIST_BITS + 16;
    localparam int SUMW = ((DIST_BITS > RW) ? DIST_BITS : RW) + 1;
    localparam int XW   = (DIST_BITS > OVR_W - 1) ? DIST_BITS : OVR_W - 1;
    localparam int QW   = (NW > ETA_W) ? NW : ETA_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_ETA  = 4'd6;
    localparam logic [3:0] S_DMUL = 4'd7;
    localparam logic [3:0] S_DDIV = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [REG_W-1:0] speed_reg, battery_reg, drop_uv_reg, min_bat_reg;

    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, x_reg, y_reg;
    logic                         have_prev_reg, cmd_reg, last_reg;
    logic [DIST_BITS-1:0]         path_reg, dist_reg;
    logic [CNT_W-1:0]             seen_reg, count_reg;
    logic                         src_reg;
    logic [ETA_W-1:0]             eta_reg;

    logic [DIST_BITS-1:0] out_dist_reg;
    logic [ETA_W-1:0]     out_eta_reg;
    logic [DROP_W-1:0]    out_drop_reg;
    logic [PROJ_W-1:0]    out_proj_reg;
    logic                 out_suff_reg, out_src_reg, m_tvalid_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic accept;
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic [OVR_W-1:0] in_ovr;
    logic [CNT_W-1:0] in_ocnt;
    logic [XW-1:0]    ovr_ext;
    logic [DIST_BITS-1:0] ovr_dist;

    logic signed [COORD_BITS:0] dx_s, dy_s;
    logic [DXW-1:0] dx, dy;

    logic           mul_start, sqrt_start, div_start;
    logic [MA-1:0]  mul_a;
    logic [MB-1:0]  mul_b;
    logic [MA+MB-1:0] prod;
    logic [MA+MB-1:0] sq_reg;
    logic [2*RW-1:0]  rad;
    logic [RW-1:0]    root;
    logic [NW-1:0]    div_num, div_q;
    logic [DIVR_W-1:0] div_den;
    su_stat_t mul_st, sqrt_st, div_st;

    logic [REG_W-1:0] spd;
    logic [RW-1:0]    seg;
    logic [SUMW-1:0]  path_sum;
    logic [DIST_BITS-1:0] path_new;
    logic [CNT_W-1:0] seen_new;
    logic [QW-1:0]    q_ext;
    logic [DROP_W-1:0] drop_sat;
    logic signed [PROJ_W:0] proj_full;
    logic out_load;

    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_ovr  = s_tdata[2*COORD_BITS+OVR_W-1:2*COORD_BITS];
    assign in_ocnt = s_tdata[IN_W-1:2*COORD_BITS+OVR_W];
    assign ovr_ext = XW'(in_ovr[OVR_W-2:0]);
    assign ovr_dist = in_ovr[OVR_W-1] ? '0 :
                      (ovr_ext > XW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}} :
                      DIST_BITS'(ovr_ext);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign dx_s = (COORD_BITS+1)'(x_reg) - (COORD_BITS+1)'(prev_x_reg);
    assign dy_s = (COORD_BITS+1)'(y_reg) - (COORD_BITS+1)'(prev_y_reg);
    assign dx   = dx_s[COORD_BITS] ? DXW'(-dx_s) : DXW'(dx_s);
    assign dy   = dy_s[COORD_BITS] ? DXW'(-dy_s) : DXW'(dy_s);

    assign spd = (speed_reg < SPEED_FLOOR) ? SPEED_FLOOR : speed_reg;

    always_comb
    begin
        mul_a = MA'(dx);
        mul_b = MB'(dx);
        if (state_reg == S_SQX)
        begin
            mul_a = MA'(dy);
            mul_b = MB'(dy);
        end
        else if (state_reg == S_ETA)
        begin
            mul_a = MA'(dist_reg);
            mul_b = MB'(drop_uv_reg);
        end
    end

    assign rad = (2*RW)'(sq_reg) + (2*RW)'(prod);

    always_comb
    begin
        if (state_reg == S_DMUL)
        begin
            div_num = prod[NW-1:0];
            div_den = DROP_DIVISOR;
        end
        else
        begin
            div_num = (NW'(path_new) << 10) - (NW'(path_new) << 4) - (NW'(path_new) << 3);
            div_den = DIVR_W'(spd);
            if (state_reg == S_DISP)
            begin
                div_num = (NW'(dist_reg) << 10) - (NW'(dist_reg) << 4)
                          - (NW'(dist_reg) << 3);
            end
        end
    end

    assign seg      = have_prev_reg ? root : '0;
    assign path_sum = SUMW'(path_reg) + SUMW'(seg);
    assign path_new = (path_sum > SUMW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                          : DIST_BITS'(path_sum);
    assign seen_new = (seen_reg == {CNT_W{1'b1}}) ? seen_reg : seen_reg + 1'b1;

    assign q_ext    = QW'(div_q);
    assign drop_sat = (div_q > NW'({DROP_W{1'b1}})) ? {DROP_W{1'b1}} : DROP_W'(div_q);
    assign proj_full = $signed({{(PROJ_W+1-REG_W){1'b0}}, battery_reg})
                       - $signed({{(PROJ_W+1-DROP_W){1'b0}}, drop_sat});

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (cmd_reg == CMD_OVERRIDE)
                begin
                    div_start  = 1'b1;
                    state_next = S_ETA;
                end
                else if (have_prev_reg)
                begin
                    mul_start  = 1'b1;
                    state_next = S_SQX;
                end
                else
                begin
                    state_next = S_ACC;
                end
            end
            S_SQX:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (mul_st.done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_st.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (last_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_ETA;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ETA:
            begin
                if (div_st.done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                if (mul_st.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                if (div_st.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= SPEED_RESET;
            battery_reg   <= '0;
            drop_uv_reg   <= '0;
            min_bat_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            path_reg      <= '0;
            seen_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SPEED:   speed_reg   <= cfg_data;
                    REG_BATTERY: battery_reg <= cfg_data;
                    REG_DROP:    drop_uv_reg <= cfg_data;
                    REG_MIN_BAT: min_bat_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (state_reg == S_ACC)
            begin
                if (last_reg)
                begin
                    prev_x_reg    <= '0;
                    prev_y_reg    <= '0;
                    have_prev_reg <= 1'b0;
                    path_reg      <= '0;
                    seen_reg      <= '0;
                end
                else
                begin
                    prev_x_reg    <= x_reg;
                    prev_y_reg    <= y_reg;
                    have_prev_reg <= 1'b1;
                    path_reg      <= path_new;
                    seen_reg      <= seen_new;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            last_reg  <= s_tlast;
            x_reg     <= in_x;
            y_reg     <= in_y;
            dist_reg  <= ovr_dist;
            count_reg <= in_ocnt;
            src_reg   <= SRC_OVERRIDE;
        end
        else if (state_reg == S_ACC)
        begin
            dist_reg  <= path_new;
            count_reg <= seen_new;
            src_reg   <= SRC_PATH;
        end
        if (state_reg == S_SQY && mul_st.done)
        begin
            sq_reg <= sq_reg;
        end
        else if (state_reg == S_SQX && mul_st.done)
        begin
            sq_reg <= prod;
        end
        if (state_reg == S_ETA && div_st.done)
        begin
            eta_reg <= (q_ext > QW'({ETA_W{1'b1}})) ? {ETA_W{1'b1}} : ETA_W'(q_ext);
        end
        if (state_reg == S_DDIV && div_st.done)
        begin
            out_drop_reg <= drop_sat;
            out_proj_reg <= PROJ_W'(proj_full);
            out_suff_reg <= (battery_reg == '0) ||
                            (proj_full >= $signed({{(PROJ_W+1-REG_W){1'b0}}, min_bat_reg}));
        end
        if (out_load)
        begin
            out_dist_reg  <= dist_reg;
            out_eta_reg   <= eta_reg;
            out_count_reg <= count_reg;
            out_src_reg   <= src_reg;
        end
    end

    // Hold drop, projection and flag in staging until the output request is free.
    logic [DROP_W-1:0] m_drop_reg;
    logic [PROJ_W-1:0] m_proj_reg;
    logic              m_suff_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_drop_reg <= out_drop_reg;
            m_proj_reg <= out_proj_reg;
            m_suff_reg <= out_suff_reg;
        end
    end

    wpce_smul #(.AW(MA), .BW(MB)) u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .stat  (mul_st)
    );

    wpce_ssqrt #(.RW(RW)) u_ssqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (rad),
        .root  (root),
        .stat  (sqrt_st)
    );

    wpce_sdiv #(.NW(NW), .DW(DIVR_W)) u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .stat  (div_st)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_src_reg;
    assign m_tdata  = OUT_TW'({out_count_reg, m_suff_reg, m_proj_reg, m_drop_reg,
                               out_eta_reg, out_dist_reg});
endmodule
`default_nettype wire

/* sv/wpce_checker.sv */
// Port-level checker for the waypoint path cost estimator, with its bind.
// Depends on wpce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wpce_checker
    import wpce_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEF,
    parameter int OUT_TW    = 160
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_TW-1:0] m_tdata
);
    logic dist_zero, eta_zero, drop_zero;

    assign dist_zero = (m_tdata[DIST_BITS-1:0] == '0);
    assign eta_zero  = (m_tdata[DIST_BITS+ETA_W-1:DIST_BITS] == '0);
    assign drop_zero = (m_tdata[DIST_BITS+ETA_W+DROP_W-1:DIST_BITS+ETA_W] == '0);

    `WPCE_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `WPCE_ASSERT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")
    `WPCE_ASSERT(a_zero_dist, clk, rst_n, m_tvalid && dist_zero |-> eta_zero && drop_zero, "nonzero cost for zero distance")
endmodule

bind waypoint_path_cost_estimator wpce_checker #(
    .DIST_BITS (DIST_BITS),
    .OUT_TW    (OUT_TW)
) u_wpce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
